// File: rtl/sit_pkg.sv
// shared types and constants of the segment intersection test
`timescale 1ns / 1ps
`default_nettype none
package sit_pkg;

   localparam int SIT_ORIENT_STAGES = 3;
   localparam int SIT_LATENCY       = SIT_ORIENT_STAGES + 1;

   typedef struct packed {
      logic neg;
      logic zero;
   } sit_sign_type;

endpackage
`default_nettype wire

// File: rtl/sit_orient.sv
// three-stage orientation pipeline: edge p->q against point r
`timescale 1ns / 1ps
`default_nettype none
module sit_orient #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic signed [COORD_BITS-1:0] p_x,
   input  wire logic signed [COORD_BITS-1:0] p_y,
   input  wire logic signed [COORD_BITS-1:0] q_x,
   input  wire logic signed [COORD_BITS-1:0] q_y,
   input  wire logic signed [COORD_BITS-1:0] r_x,
   input  wire logic signed [COORD_BITS-1:0] r_y,
   output sit_pkg::sit_sign_type             sign
);
   import sit_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   logic signed [DW-1:0] ux_in, uy_in, vx_in, vy_in;
   logic signed [DW-1:0] ux_ff, uy_ff, vx_ff, vy_ff;
   logic signed [PW-1:0] prod_a_in, prod_b_in;
   logic signed [PW-1:0] prod_a_ff, prod_b_ff;
   logic signed [SW-1:0] diff;
   sit_sign_type         sign_in, sign_ff;

   // stage 1: edge and point vectors
   assign ux_in = DW'(q_x) - DW'(p_x);
   assign uy_in = DW'(q_y) - DW'(p_y);
   assign vx_in = DW'(r_x) - DW'(q_x);
   assign vy_in = DW'(r_y) - DW'(q_y);

   // stage 2: cross product terms
   assign prod_a_in = PW'(ux_ff) * PW'(vy_ff);
   assign prod_b_in = PW'(uy_ff) * PW'(vx_ff);

   // stage 3: sign of the difference
   assign diff         = SW'(prod_a_ff) - SW'(prod_b_ff);
   assign sign_in.neg  = diff[SW-1];
   assign sign_in.zero = (diff == '0);

   always_ff @(posedge clock) begin
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      sign_ff   <= sign_in;
   end

   assign sign = sign_ff;

endmodule
`default_nettype wire

// File: rtl/sit_box.sv
// bounding-box test of r against p,q, delayed to match the orientation pipeline
`timescale 1ns / 1ps
`default_nettype none
module sit_box #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic signed [COORD_BITS-1:0] p_x,
   input  wire logic signed [COORD_BITS-1:0] p_y,
   input  wire logic signed [COORD_BITS-1:0] q_x,
   input  wire logic signed [COORD_BITS-1:0] q_y,
   input  wire logic signed [COORD_BITS-1:0] r_x,
   input  wire logic signed [COORD_BITS-1:0] r_y,
   output logic                              in_box
);
   import sit_pkg::*;

   logic                         in_x, in_y;
   logic [SIT_ORIENT_STAGES-1:0] box_in, box_ff;

   assign in_x = ((p_x <= r_x) && (r_x <= q_x)) || ((q_x <= r_x) && (r_x <= p_x));
   assign in_y = ((p_y <= r_y) && (r_y <= q_y)) || ((q_y <= r_y) && (r_y <= p_y));

   assign box_in = {box_ff[SIT_ORIENT_STAGES-2:0], in_x & in_y};

   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   assign in_box = box_ff[SIT_ORIENT_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/segment_intersection_test.sv
// top level of the segment intersection test
// Usage:
//  - drive the eight endpoint coordinates on the req_ ports and raise start;
//    a transfer takes place at each rising edge with start high and busy low
//  - busy is low at all times except while reset is held, so a new pair of
//    segments may be transferred in every clock cycle
//  - each transfer yields one result: rsp_valid is high for one cycle with
//    rsp_segments_meet
//  - registered steps, in order: vector differences, the eight cross product
//    multipliers, the sign of each cross product, and the final combine;
//    throughput is one pair per cycle, set by the fully registered pipeline
//  - results appear in input order; the receiver cannot hold them off and
//    never needs to, since nothing in the pipeline waits
//  - a synchronous reset clears the valid bits, dropping items in flight
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_test #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_end_y,
   output logic                              rsp_valid,
   output logic                              rsp_segments_meet
);
   import sit_pkg::*;

   sit_sign_type d1, d2, d3, d4;
   logic         box1, box2, box3, box4;
   logic         accept;
   logic [SIT_LATENCY-1:0] valid_in, valid_ff;
   logic         meet_in, meet_ff;
   logic         pos1, pos2, pos3, pos4, straddle;

   assign busy   = reset;
   assign accept = start & ~busy;

   // orientation of a0, a1 against b, then b0, b1 against a
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_1 (
      .clock(clock),
      .p_x(req_seg_b_start_x), .p_y(req_seg_b_start_y),
      .q_x(req_seg_b_end_x),   .q_y(req_seg_b_end_y),
      .r_x(req_seg_a_start_x), .r_y(req_seg_a_start_y),
      .sign(d1)
   );
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_2 (
      .clock(clock),
      .p_x(req_seg_b_start_x), .p_y(req_seg_b_start_y),
      .q_x(req_seg_b_end_x),   .q_y(req_seg_b_end_y),
      .r_x(req_seg_a_end_x),   .r_y(req_seg_a_end_y),
      .sign(d2)
   );
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_3 (
      .clock(clock),
      .p_x(req_seg_a_start_x), .p_y(req_seg_a_start_y),
      .q_x(req_seg_a_end_x),   .q_y(req_seg_a_end_y),
      .r_x(req_seg_b_start_x), .r_y(req_seg_b_start_y),
      .sign(d3)
   );
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_4 (
      .clock(clock),
      .p_x(req_seg_a_start_x), .p_y(req_seg_a_start_y),
      .q_x(req_seg_a_end_x),   .q_y(req_seg_a_end_y),
      .r_x(req_seg_b_end_x),   .r_y(req_seg_b_end_y),
      .sign(d4)
   );

   sit_box #(.COORD_BITS(COORD_BITS)) u_box_1 (
      .clock(clock),
      .p_x(req_seg_b_start_x), .p_y(req_seg_b_start_y),
      .q_x(req_seg_b_end_x),   .q_y(req_seg_b_end_y),
      .r_x(req_seg_a_start_x), .r_y(req_seg_a_start_y),
      .in_box(box1)
   );
   sit_box #(.COORD_BITS(COORD_BITS)) u_box_2 (
      .clock(clock),
      .p_x(req_seg_b_start_x), .p_y(req_seg_b_start_y),
      .q_x(req_seg_b_end_x),   .q_y(req_seg_b_end_y),
      .r_x(req_seg_a_end_x),   .r_y(req_seg_a_end_y),
      .in_box(box2)
   );
   sit_box #(.COORD_BITS(COORD_BITS)) u_box_3 (
      .clock(clock),
      .p_x(req_seg_a_start_x), .p_y(req_seg_a_start_y),
      .q_x(req_seg_a_end_x),   .q_y(req_seg_a_end_y),
      .r_x(req_seg_b_start_x), .r_y(req_seg_b_start_y),
      .in_box(box3)
   );
   sit_box #(.COORD_BITS(COORD_BITS)) u_box_4 (
      .clock(clock),
      .p_x(req_seg_a_start_x), .p_y(req_seg_a_start_y),
      .q_x(req_seg_a_end_x),   .q_y(req_seg_a_end_y),
      .r_x(req_seg_b_end_x),   .r_y(req_seg_b_end_y),
      .in_box(box4)
   );

   assign pos1 = ~d1.neg & ~d1.zero;
   assign pos2 = ~d2.neg & ~d2.zero;
   assign pos3 = ~d3.neg & ~d3.zero;
   assign pos4 = ~d4.neg & ~d4.zero;

   assign straddle = ((d1.neg & pos2) | (pos1 & d2.neg)) &
                     ((d3.neg & pos4) | (pos3 & d4.neg));

   assign meet_in = straddle | (d1.zero & box1) | (d2.zero & box2) |
                    (d3.zero & box3) | (d4.zero & box4);

   assign valid_in = {valid_ff[SIT_LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meet_ff <= meet_in;
   end

   assign rsp_valid         = valid_ff[SIT_LATENCY-1];
   assign rsp_segments_meet = meet_ff;

endmodule
`default_nettype wire

// File: tb/segment_intersection_test_tb.sv
// self-checking testbench for the segment intersection test
`timescale 1ns / 1ps
module segment_intersection_test_tb;
   import sit_pkg::*;

   localparam int COORD_BITS = 16;
   localparam int STALL_LIMIT = 1000;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } seg_pair_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_seg_a_start_x = '0;
   coord_type req_seg_a_start_y = '0;
   coord_type req_seg_a_end_x = '0;
   coord_type req_seg_a_end_y = '0;
   coord_type req_seg_b_start_x = '0;
   coord_type req_seg_b_start_y = '0;
   coord_type req_seg_b_end_x = '0;
   coord_type req_seg_b_end_y = '0;
   logic      rsp_valid;
   logic      rsp_segments_meet;

   bit meet_expected_q[$];
   int mismatch_count = 0;
   int stall_cycles = 0;
   bit gaps_on = 1'b1;

   segment_intersection_test #(
      .COORD_BITS(COORD_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_seg_a_start_x(req_seg_a_start_x),
      .req_seg_a_start_y(req_seg_a_start_y),
      .req_seg_a_end_x(req_seg_a_end_x),
      .req_seg_a_end_y(req_seg_a_end_y),
      .req_seg_b_start_x(req_seg_b_start_x),
      .req_seg_b_start_y(req_seg_b_start_y),
      .req_seg_b_end_x(req_seg_b_end_x),
      .req_seg_b_end_y(req_seg_b_end_y),
      .rsp_valid(rsp_valid),
      .rsp_segments_meet(rsp_segments_meet)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // sign of (q - p) x (r - q), exact in 64 bits
   function automatic int cross_sign(input coord_type px, py, qx, qy, rx, ry);
      longint ux, uy, vx, vy, cross_val;
      ux = longint'(qx) - longint'(px);
      uy = longint'(qy) - longint'(py);
      vx = longint'(rx) - longint'(qx);
      vy = longint'(ry) - longint'(qy);
      cross_val = ux * vy - uy * vx;
      return (cross_val > 0) ? 1 : ((cross_val < 0) ? -1 : 0);
   endfunction

   function automatic bit within_box(input coord_type px, py, qx, qy, rx, ry);
      coord_type lo_x, hi_x, lo_y, hi_y;
      lo_x = (px < qx) ? px : qx;
      hi_x = (px < qx) ? qx : px;
      lo_y = (py < qy) ? py : qy;
      hi_y = (py < qy) ? qy : py;
      return (lo_x <= rx) && (rx <= hi_x) && (lo_y <= ry) && (ry <= hi_y);
   endfunction

   function automatic bit segments_meet_predict(input seg_pair_type s);
      int o1, o2, o3, o4;
      o1 = cross_sign(s.b_start_x, s.b_start_y, s.b_end_x, s.b_end_y,
                      s.a_start_x, s.a_start_y);
      o2 = cross_sign(s.b_start_x, s.b_start_y, s.b_end_x, s.b_end_y,
                      s.a_end_x, s.a_end_y);
      o3 = cross_sign(s.a_start_x, s.a_start_y, s.a_end_x, s.a_end_y,
                      s.b_start_x, s.b_start_y);
      o4 = cross_sign(s.a_start_x, s.a_start_y, s.a_end_x, s.a_end_y,
                      s.b_end_x, s.b_end_y);
      if (o1 * o2 < 0 && o3 * o4 < 0)
         return 1'b1;
      if (o1 == 0 && within_box(s.b_start_x, s.b_start_y, s.b_end_x, s.b_end_y,
                                s.a_start_x, s.a_start_y))
         return 1'b1;
      if (o2 == 0 && within_box(s.b_start_x, s.b_start_y, s.b_end_x, s.b_end_y,
                                s.a_end_x, s.a_end_y))
         return 1'b1;
      if (o3 == 0 && within_box(s.a_start_x, s.a_start_y, s.a_end_x, s.a_end_y,
                                s.b_start_x, s.b_start_y))
         return 1'b1;
      if (o4 == 0 && within_box(s.a_start_x, s.a_start_y, s.a_end_x, s.a_end_y,
                                s.b_end_x, s.b_end_y))
         return 1'b1;
      return 1'b0;
   endfunction

   function automatic seg_pair_type make_pair(input int ax0, ay0, ax1, ay1,
                                              input int bx0, by0, bx1, by1);
      seg_pair_type s;
      s.a_start_x = coord_type'(ax0);
      s.a_start_y = coord_type'(ay0);
      s.a_end_x   = coord_type'(ax1);
      s.a_end_y   = coord_type'(ay1);
      s.b_start_x = coord_type'(bx0);
      s.b_start_y = coord_type'(by0);
      s.b_end_x   = coord_type'(bx1);
      s.b_end_y   = coord_type'(by1);
      return s;
   endfunction

   function automatic seg_pair_type uniform_pair();
      return make_pair($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
   endfunction

   // all points inside a 7x7 window, so touching and collinear cases are common
   function automatic seg_pair_type grid_pair();
      int ox, oy;
      seg_pair_type s;
      case ($urandom_range(0, 3))
         0: begin
            ox = -32768;
            oy = 32761;
         end
         1: begin
            ox = 32761;
            oy = -32768;
         end
         default: begin
            ox = $urandom_range(0, 65529) - 32768;
            oy = $urandom_range(0, 65529) - 32768;
         end
      endcase
      s = make_pair(ox + $urandom_range(0, 6), oy + $urandom_range(0, 6),
                    ox + $urandom_range(0, 6), oy + $urandom_range(0, 6),
                    ox + $urandom_range(0, 6), oy + $urandom_range(0, 6),
                    ox + $urandom_range(0, 6), oy + $urandom_range(0, 6));
      if ($urandom_range(0, 4) == 0) begin
         s.b_start_x = s.a_end_x;
         s.b_start_y = s.a_end_y;
      end
      return s;
   endfunction

   // four points on one line, sometimes with one nudged off it
   function automatic seg_pair_type collinear_pair();
      int bx, by, dx, dy, k0, k1, k2, k3;
      seg_pair_type s;
      bx = $urandom_range(0, 16000) - 8000;
      by = $urandom_range(0, 16000) - 8000;
      if ($urandom_range(0, 1) == 0) begin
         dx = $urandom_range(0, 6) - 3;
         dy = $urandom_range(0, 6) - 3;
      end else begin
         dx = $urandom_range(0, 80) - 40;
         dy = $urandom_range(0, 80) - 40;
      end
      k0 = $urandom_range(0, 12) - 6;
      k1 = $urandom_range(0, 12) - 6;
      k2 = $urandom_range(0, 12) - 6;
      k3 = $urandom_range(0, 12) - 6;
      s = make_pair(bx + k0 * dx, by + k0 * dy, bx + k1 * dx, by + k1 * dy,
                    bx + k2 * dx, by + k2 * dy, bx + k3 * dx, by + k3 * dy);
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1) == 0)
            s.b_end_x = coord_type'(s.b_end_x + (($urandom_range(0, 1) == 0) ? 1 : -1));
         else
            s.a_start_y = coord_type'(s.a_start_y + (($urandom_range(0, 1) == 0) ? 1 : -1));
      end
      return s;
   endfunction

   task automatic send_pair(input seg_pair_type s);
      @(negedge clock);
      if (gaps_on) begin
         while ($urandom_range(0, 99) < 9) begin
            start = 1'b0;
            @(negedge clock);
         end
      end
      req_seg_a_start_x = s.a_start_x;
      req_seg_a_start_y = s.a_start_y;
      req_seg_a_end_x   = s.a_end_x;
      req_seg_a_end_y   = s.a_end_y;
      req_seg_b_start_x = s.b_start_x;
      req_seg_b_start_y = s.b_start_y;
      req_seg_b_end_x   = s.b_end_x;
      req_seg_b_end_y   = s.b_end_y;
      start = 1'b1;
      do @(posedge clock); while (busy);
      meet_expected_q.insert(meet_expected_q.size(), segments_meet_predict(s));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (meet_expected_q.size() == 0) begin
            $error("unexpected result transfer: segments_meet %0b", rsp_segments_meet);
            mismatch_count++;
         end else begin
            bit want;
            want = meet_expected_q.pop_front();
            if (rsp_segments_meet !== want) begin
               $error("segments_meet: expected %0b, actual %0b", want, rsp_segments_meet);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("segment_intersection_test regression: fail");
         $finish;
      end
   end

   task automatic test_directed();
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      send_pair(make_pair(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767));
      send_pair(make_pair(0, 0, 4, 4, 0, 4, 4, 0));
      send_pair(make_pair(0, 0, 4, 0, 2, 0, 2, 5));
      send_pair(make_pair(0, 0, 3, 3, 3, 3, 6, 0));
      send_pair(make_pair(0, 0, 4, 0, 2, 0, 6, 0));
      send_pair(make_pair(0, 0, 2, 0, 3, 0, 5, 0));
      send_pair(make_pair(0, 0, 2, 2, 2, 2, 5, 5));
      send_pair(make_pair(1, 1, 1, 1, 0, 0, 2, 2));
      send_pair(make_pair(3, 3, 3, 3, 0, 0, 2, 2));
      send_pair(make_pair(1, 2, 1, 2, 0, 0, 2, 2));
      send_pair(make_pair(1, 1, 1, 1, 1, 2, 1, 2));
      send_pair(make_pair(0, 0, 1, 1, 3, 0, 0, 3));
      send_pair(make_pair(-32768, 0, 32767, 0, 32767, 0, 32767, 0));
      send_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
      send_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 0, 32767));
      send_pair(make_pair(0, -32768, 0, 32767, 1, -32768, 1, 32767));
      send_pair(make_pair(5, 5, -5, -5, 1, 1, 2, 2));
      send_pair(make_pair(32767, -32768, -32768, 32767, 0, 0, -1, -1));
   endtask

   task automatic test_random_uniform();
      repeat (500) send_pair(uniform_pair());
   endtask

   task automatic test_random_grid();
      repeat (700) send_pair(grid_pair());
   endtask

   task automatic test_random_collinear();
      repeat (500) send_pair(collinear_pair());
   endtask

   // back-to-back transfers with no idle cycles
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      repeat (300) begin
         case ($urandom_range(0, 2))
            0: send_pair(uniform_pair());
            1: send_pair(grid_pair());
            default: send_pair(collinear_pair());
         endcase
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_uniform();
      test_back_to_back();
      test_random_grid();
      test_random_collinear();
      @(negedge clock);
      start = 1'b0;
      while (meet_expected_q.size() != 0)
         @(posedge clock);
      repeat (SIT_LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("segment_intersection_test regression: pass");
      else
         $display("segment_intersection_test regression: fail");
      $finish;
   end

endmodule
